// ===== hw/rtl/pli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg - positional list shared definitions
// Widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 7;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [LEN_W-1:0]          len_type;
   typedef logic [COUNT_W-1:0]        count_type;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_READ_ALL  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // what every cell does this cycle
   typedef enum logic [1:0] {
      CMD_HOLD     = 2'd0,
      CMD_INSERT   = 2'd1,
      CMD_DELETE   = 2'd2,
      CMD_ROTATE   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      idx_type tgt;
      len_type len;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/pli_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_req_if - request channel
// Valid/ready channel carrying one list operation per transaction.
// ----------------------------------------------------------------------------
interface pli_req_if import pli_pkg::*; ();
   logic      valid;
   logic      ready;
   logic [2:0] op;
   value_type value;
   pos_type   position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// ===== hw/rtl/pli_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_rsp_if - response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface pli_rsp_if import pli_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type element;
   logic      has_element;
   logic [1:0] status;
   count_type count;
   logic      last;

   modport source (output valid, output element, output has_element, output status,
                   output count, output last, input ready);
   modport sink   (input valid, input element, input has_element, input status,
                   input count, input last, output ready);
endinterface

// ===== hw/rtl/pli_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_cell - one list cell
// Holds one entry and takes a neighbour's entry, the new value or the head on insert, delete or rotate.
// ----------------------------------------------------------------------------
module pli_cell import pli_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  idx_type       idx,
   input  value_type     ins_value,
   input  value_type     left_data,
   input  value_type     right_data,
   input  value_type     wrap_data,
   output value_type     data
);

   value_type entry_ff;
   value_type entry_in;
   len_type   idx_p1;

   assign idx_p1 = LEN_W'(idx) + LEN_W'(1);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.cmd)
         CMD_HOLD: begin
            entry_in = entry_ff;
         end
         CMD_INSERT: begin
            if (idx > ctrl.tgt) begin
               entry_in = left_data;
            end else if (idx == ctrl.tgt) begin
               entry_in = ins_value;
            end
         end
         CMD_DELETE: begin
            if (idx >= ctrl.tgt) begin
               entry_in = right_data;
            end
         end
         CMD_ROTATE: begin
            // last occupied cell takes the head, the cells before it move one place towards cell 0
            if (idx_p1 == ctrl.len) begin
               entry_in = wrap_data;
            end else if (idx_p1 < ctrl.len) begin
               entry_in = right_data;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;

endmodule

// ===== hw/rtl/positional_list_insert_delete_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top - bounded positional list
// Ordered list of up to DEPTH signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, cell 0 being the front. On an insert
// or delete transaction the cells from the target position on all move one
// place at the same clock edge that accepts it, and the single result appears
// in the response register on the next cycle. A read_all transaction gives
// one result per element, one per cycle while the response side takes them,
// by rotating the chain towards cell 0 and sending out cell 0 each time;
// after length rotations the order is back as it was. An empty list gives
// one empty result. A new request is taken once the read-out is finished
// and the response register is free or being emptied. Position errors, a
// full list or an empty list are reported in status and leave the list
// untouched; every result carries the count after the operation.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top import pli_pkg::*; (
   input logic        clock,
   input logic        reset,
   pli_req_if.sink    req,
   pli_rsp_if.source  rsp
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   len_type       len_ff, len_in;
   len_type       rd_cnt_ff, rd_cnt_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   value_type     element_ff, element_in;
   logic          has_ff, has_in;
   status_type    status_ff, status_in;
   count_type     count_ff, count_in;
   logic          last_ff, last_in;

   logic          out_free;
   logic          accept;
   logic          full;
   logic          empty;
   logic          pos_ok_ins;
   logic          pos_ok_del;
   pos_type       len_pos;
   pos_type       pos_m1;
   logic          rd_last;

   // decode of the request
   cmd_type       dec_cmd;
   idx_type       dec_tgt;
   status_type    dec_status;
   len_type       dec_len;

   cell_ctrl_type cell_ctrl;
   value_type     cell_data  [DEPTH];
   value_type     left_tap   [DEPTH];
   value_type     right_tap  [DEPTH];

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req.ready  = (state_ff == S_IDLE) && out_free;
   assign accept     = req.valid && req.ready;

   assign full       = (len_ff == LEN_W'(DEPTH));
   assign empty      = (len_ff == '0);
   assign len_pos    = POS_W'(len_ff);
   assign pos_m1     = req.position - POS_W'(1);
   assign pos_ok_ins = (req.position != '0) && (pos_m1 <= len_pos);
   assign pos_ok_del = (req.position != '0) && (req.position <= len_pos);
   assign rd_last    = ((rd_cnt_ff + LEN_W'(1)) == len_ff);

   // operation decode: what the chain does and what the result says
   always_comb begin
      dec_cmd    = CMD_HOLD;
      dec_tgt    = '0;
      dec_status = ST_OK;
      dec_len    = len_ff;
      case (req.op)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_cmd = CMD_INSERT;
               dec_tgt = (req.op == OP_INS_FRONT) ? '0 : len_ff[IDX_W-1:0];
               dec_len = len_ff + LEN_W'(1);
            end
         end
         OP_INS_AT: begin
            if (!pos_ok_ins) begin
               dec_status = ST_BAD_POS;
            end else if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_cmd = CMD_INSERT;
               dec_tgt = pos_m1[IDX_W-1:0];
               dec_len = len_ff + LEN_W'(1);
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_cmd = CMD_DELETE;
               dec_tgt = (req.op == OP_DEL_FRONT) ? '0 : IDX_W'(len_ff - LEN_W'(1));
               dec_len = len_ff - LEN_W'(1);
            end
         end
         OP_DEL_AT: begin
            if (!pos_ok_del) begin
               dec_status = ST_BAD_POS;
            end else begin
               dec_cmd = CMD_DELETE;
               dec_tgt = pos_m1[IDX_W-1:0];
               dec_len = len_ff - LEN_W'(1);
            end
         end
         default: begin
            // read_all and the unused code leave the list as it is
            dec_cmd = CMD_HOLD;
         end
      endcase
   end

   // sequencer and response register
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      rd_cnt_in     = rd_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      element_in    = element_ff;
      has_in        = has_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      cell_ctrl.cmd = CMD_HOLD;
      cell_ctrl.tgt = dec_tgt;
      cell_ctrl.len = len_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((req.op == OP_READ_ALL) && !empty) begin
                  state_in  = S_READ;
                  rd_cnt_in = '0;
               end else begin
                  cell_ctrl.cmd = dec_cmd;
                  len_in        = dec_len;
                  rsp_valid_in  = 1'b1;
                  element_in    = '0;
                  has_in        = 1'b0;
                  status_in     = dec_status;
                  count_in      = COUNT_W'(dec_len);
                  last_in       = 1'b1;
               end
            end
         end
         S_READ: begin
            if (out_free) begin
               // send the head and rotate the next element into cell 0
               cell_ctrl.cmd = CMD_ROTATE;
               rsp_valid_in  = 1'b1;
               element_in    = cell_data[0];
               has_in        = 1'b1;
               status_in     = ST_OK;
               count_in      = COUNT_W'(len_ff);
               last_in       = rd_last;
               rd_cnt_in     = rd_cnt_ff + LEN_W'(1);
               if (rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      element_ff <= element_in;
      has_ff     <= has_in;
      status_ff  <= status_in;
      count_ff   <= count_in;
      last_ff    <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.element     = element_ff;
   assign rsp.has_element = has_ff;
   assign rsp.status      = status_ff;
   assign rsp.count       = count_ff;
   assign rsp.last        = last_ff;

   // chain of cells, cell 0 at the front of the list
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_tap[i] = '0;
      end else begin : g_mid_left
         assign left_tap[i] = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign right_tap[i] = '0;
      end else begin : g_mid_right
         assign right_tap[i] = cell_data[i+1];
      end

      pli_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .idx        (IDX_W'(i)),
         .ins_value  (req.value),
         .left_data  (left_tap[i]),
         .right_data (right_tap[i]),
         .wrap_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   // checks
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(DEPTH))
      else $error("list length beyond depth");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      accept && (req.op != OP_READ_ALL) |=> rsp.valid && rsp.last && !rsp.has_element)
      else $error("non read-out transaction did not give one final result");

   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !req.ready && !empty)
      else $error("request taken during read-out");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (dec_cmd == CMD_INSERT) |=> len_ff == $past(len_ff) + LEN_W'(1))
      else $error("insert did not grow the list by one");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) && out_free |=> rsp.count == COUNT_W'(len_ff))
      else $error("read-out result carries wrong count");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - bounded positional list testbench
// Drives list operations over the request channel and checks every response
// against a predictor holding its own copy of the list. A directed table comes
// first (empty list, bad positions, full list, extreme values, every opcode),
// then random well-formed traffic with some noise, under random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_top import pli_pkg::*; ();

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_ITEMS  = 500;
   localparam int LONG_HOLD     = 400;         // receiver hold-off, in cycles
   localparam int HOLD_AT_ITEM  = 120;         // random transaction that triggers it
   localparam int DRAIN_AT_ITEM = 320;         // random transaction before which we drain
   localparam int STALL_LIMIT   = 3000;        // cycles with no transaction at all
   localparam int DRAIN_CYCLES  = 2 * DEPTH + 8;

   // opcode the block does not define: must give a plain ok result
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // one response as the list should produce it
   typedef struct {
      value_type  element;
      logic       has_element;
      status_type status;
      count_type  count;
      logic       last;
   } list_result_type;

   // one row of the directed table; st and cnt only count when typed is set
   typedef struct {
      logic [2:0] op;
      value_type  value;
      pos_type    pos;
      int         reps;
      bit         typed;
      status_type st;
      count_type  cnt;
   } step_row_type;

   // receiver ready patterns
   typedef enum int {
      RX_FREE   = 0,
      RX_COIN   = 1,
      RX_THIRDS = 2,
      RX_SPARSE = 3
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #HALF_PERIOD clock = ~clock;

   pli_req_if req_if ();
   pli_rsp_if rsp_if ();

   positional_list_insert_delete_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // predictor state: our own copy of the cells and the length
   value_type       list_cells [DEPTH];
   int              list_len = 0;
   list_result_type list_results_due [$];

   // bookkeeping
   int  mismatches   = 0;
   int  items_sent   = 0;
   int  results_seen = 0;
   int  readouts     = 0;
   int  full_rejects = 0;
   int  peak_len     = 0;
   int  holds_done   = 0;
   int  quiet_cycles = 0;
   int  burst_left   = 0;
   bit  rsp_hold_req = 1'b0;

   // directed table: empty list cases, bad positions at both ends, extreme
   // values, the unused opcode, a fill to full and the full-list refusals,
   // a full-length read-out and a drain back to empty
   step_row_type directed_steps [28] = '{
      '{OP_READ_ALL,  32'sd0,          8'd0,   1,  1'b1, ST_OK,      7'd0},
      '{OP_DEL_FRONT, 32'sd0,          8'd0,   1,  1'b1, ST_EMPTY,   7'd0},
      '{OP_DEL_BACK,  32'sd0,          8'd0,   1,  1'b1, ST_EMPTY,   7'd0},
      '{OP_DEL_AT,    32'sd0,          8'd1,   1,  1'b1, ST_BAD_POS, 7'd0},
      '{OP_INS_AT,    32'sd5,          8'd0,   1,  1'b1, ST_BAD_POS, 7'd0},
      '{OP_INS_AT,    32'sd5,          8'd2,   1,  1'b1, ST_BAD_POS, 7'd0},
      '{OP_INS_AT,    32'sh7FFF_FFFF,  8'd1,   1,  1'b1, ST_OK,      7'd1},
      '{OP_INS_FRONT, 32'sh8000_0000,  8'd0,   1,  1'b1, ST_OK,      7'd2},
      '{OP_INS_BACK,  -32'sd1,         8'd0,   1,  1'b1, ST_OK,      7'd3},
      '{OP_INS_AT,    32'sd9,          8'd255, 1,  1'b1, ST_BAD_POS, 7'd3},
      '{OP_DEL_AT,    32'sd0,          8'd0,   1,  1'b1, ST_BAD_POS, 7'd3},
      '{OP_DEL_AT,    32'sd0,          8'd4,   1,  1'b1, ST_BAD_POS, 7'd3},
      '{OP_INS_AT,    32'sd0,          8'd2,   1,  1'b0, ST_OK,      7'd0},
      '{OP_READ_ALL,  32'sd0,          8'd0,   1,  1'b0, ST_OK,      7'd0},
      '{OP_UNUSED,    32'sh1234_5678,  8'd3,   1,  1'b1, ST_OK,      7'd4},
      '{OP_DEL_AT,    32'sd0,          8'd2,   1,  1'b1, ST_OK,      7'd3},
      '{OP_DEL_BACK,  32'sd0,          8'd0,   1,  1'b1, ST_OK,      7'd2},
      '{OP_DEL_FRONT, 32'sd0,          8'd0,   1,  1'b1, ST_OK,      7'd1},
      '{OP_INS_BACK,  32'sh5A5A_0000,  8'd0,   15, 1'b0, ST_OK,      7'd0},
      '{OP_INS_FRONT, 32'sd1,          8'd0,   1,  1'b1, ST_FULL,    7'd16},
      '{OP_INS_BACK,  32'sd2,          8'd0,   1,  1'b1, ST_FULL,    7'd16},
      '{OP_INS_AT,    32'sd3,          8'd17,  1,  1'b1, ST_FULL,    7'd16},
      '{OP_INS_AT,    32'sd4,          8'd18,  1,  1'b1, ST_BAD_POS, 7'd16},
      '{OP_READ_ALL,  32'sd0,          8'd0,   1,  1'b0, ST_OK,      7'd0},
      '{OP_DEL_AT,    32'sd0,          8'd16,  1,  1'b1, ST_OK,      7'd15},
      '{OP_DEL_AT,    32'sd0,          8'd1,   1,  1'b1, ST_OK,      7'd14},
      '{OP_DEL_FRONT, 32'sd0,          8'd0,   14, 1'b0, ST_OK,      7'd0},
      '{OP_READ_ALL,  32'sd0,          8'd0,   1,  1'b1, ST_OK,      7'd0}
   };

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // open a gap at idx and put v there
   function automatic void insert_cell(input int idx, input value_type v);
      int i;
      for (i = list_len; i > idx; i--)
         list_cells[i] = list_cells[i-1];
      list_cells[idx] = v;
      list_len++;
      if (list_len > peak_len)
         peak_len = list_len;
   endfunction

   // close the gap left by removing idx
   function automatic void remove_cell(input int idx);
      int i;
      for (i = idx; i + 1 < list_len; i++)
         list_cells[i] = list_cells[i+1];
      list_len--;
   endfunction

   // apply one accepted transaction to the list and queue the responses it owes
   function automatic void apply_list_op(input logic [2:0] op, input value_type v,
                                         input pos_type p);
      list_result_type r;
      status_type      st;
      int              pos_i;
      int              i;
      pos_i = int'(p);
      st    = ST_OK;
      r     = '{element: '0, has_element: 1'b0, status: ST_OK, count: '0, last: 1'b1};
      case (op)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (list_len >= DEPTH)
               st = ST_FULL;
            else
               insert_cell((op == OP_INS_FRONT) ? 0 : list_len, v);
         end
         OP_INS_AT: begin
            // position is judged before fullness
            if (pos_i < 1 || pos_i > list_len + 1)
               st = ST_BAD_POS;
            else if (list_len >= DEPTH)
               st = ST_FULL;
            else
               insert_cell(pos_i - 1, v);
         end
         OP_DEL_FRONT, OP_DEL_BACK: begin
            if (list_len == 0)
               st = ST_EMPTY;
            else
               remove_cell((op == OP_DEL_FRONT) ? 0 : list_len - 1);
         end
         OP_DEL_AT: begin
            if (pos_i < 1 || pos_i > list_len)
               st = ST_BAD_POS;
            else
               remove_cell(pos_i - 1);
         end
         OP_READ_ALL: begin
            readouts++;
            // an empty list still owes one blank response
            if (list_len == 0) begin
               list_results_due.push_back(r);
               return;
            end
            for (i = 0; i < list_len; i++) begin
               r.element     = list_cells[i];
               r.has_element = 1'b1;
               r.count       = count_type'(list_len);
               r.last        = (i + 1 == list_len);
               list_results_due.push_back(r);
            end
            return;
         end
         default: ;
      endcase
      if (st == ST_FULL)
         full_rejects++;
      r.status = st;
      r.count  = count_type'(list_len);
      list_results_due.push_back(r);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------------
   // request side: bursts of random length with random gaps between them
   // ---------------------------------------------------------------------------

   // offer one transaction, hold it until taken, then predict its responses;
   // returns at the rising edge where it was accepted
   task automatic offer_item(input logic [2:0] op, input value_type v, input pos_type p,
                             input bit typed, input status_type st, input count_type cnt);
      int gap;
      if (burst_left == 0) begin
         // a quarter of bursts follow on with no gap at all
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid    <= 1'b1;
      req_if.op       <= op;
      req_if.value    <= v;
      req_if.position <= p;
      do
         @(posedge clock);
      while (!req_if.ready);
      apply_list_op(op, v, p);
      // rows with a hand-written expectation replace the predicted status and count
      if (typed) begin
         list_results_due[list_results_due.size() - 1].status = st;
         list_results_due[list_results_due.size() - 1].count  = cnt;
      end
      items_sent++;
   endtask

   // main stimulus
   initial begin : stimulus
      int         row;
      int         k;
      int         n;
      int         pick;
      bit         growing;
      logic [2:0] op;
      value_type  v;
      pos_type    p;

      req_if.valid    = 1'b0;
      req_if.op       = '0;
      req_if.value    = '0;
      req_if.position = '0;
      growing         = 1'b1;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed table, repeated rows step their value so cells stay distinct
      for (row = 0; row < $size(directed_steps); row++)
         for (k = 0; k < directed_steps[row].reps; k++)
            offer_item(directed_steps[row].op, directed_steps[row].value + k,
                       directed_steps[row].pos, directed_steps[row].typed,
                       directed_steps[row].st, directed_steps[row].cnt);

      // random part: the list swings between filling and draining so both the
      // full and the empty corners keep coming round
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT_ITEM)
            rsp_hold_req = 1'b1;
         if (n == DRAIN_AT_ITEM) begin
            // pause the sender until every owed response has come back
            @(negedge clock);
            req_if.valid <= 1'b0;
            while (list_results_due.size() != 0)
               @(posedge clock);
         end

         if (list_len == 0)
            growing = 1'b1;
         else if (list_len == DEPTH && $urandom_range(0, 2) == 0)
            growing = 1'b0;
         else if ($urandom_range(0, 29) == 0)
            growing = !growing;

         pick = $urandom_range(0, 99);
         if (pick < 8)
            op = OP_READ_ALL;
         else if (pick < 10)
            op = OP_UNUSED;
         else if (pick < (growing ? 75 : 35)) begin
            case ($urandom_range(0, 2))
               0:       op = OP_INS_FRONT;
               1:       op = OP_INS_BACK;
               default: op = OP_INS_AT;
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0:       op = OP_DEL_FRONT;
               1:       op = OP_DEL_BACK;
               default: op = OP_DEL_AT;
            endcase
         end

         // mostly a legal position, now and then any byte at all
         if ($urandom_range(0, 6) == 0)
            p = pos_type'($urandom_range(0, 255));
         else if (op == OP_INS_AT)
            p = pos_type'($urandom_range(1, list_len + 1));
         else
            p = pos_type'($urandom_range(1, (list_len == 0) ? 1 : list_len));

         case ($urandom_range(0, 9))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7FFF_FFFF;
            2:       v = -32'sd1;
            default: v = $urandom;
         endcase

         offer_item(op, v, p, 1'b0, ST_OK, '0);
      end

      @(negedge clock);
      req_if.valid <= 1'b0;

      // let every owed response arrive, then watch a while for strays
      while (list_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d list transactions and %0d responses, %0d read-outs, %0d full refusals",
               items_sent, results_seen, readouts, full_rejects);
      $display("peak length %0d of %0d, %0d long receiver hold-off(s), %0d mismatch(es)",
               peak_len, DEPTH, holds_done, mismatches);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // response side: ready follows a pattern chosen per stretch
   // ---------------------------------------------------------------------------
   initial begin : receiver
      rx_mode_type mode;
      int          span;
      int          phase;

      rsp_if.ready = 1'b0;
      phase        = 0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(negedge clock);
            if (rsp_hold_req) begin
               // long hold-off: the block fills up and must stall its input
               rsp_if.ready <= 1'b0;
               repeat (LONG_HOLD - 1) @(negedge clock);
               rsp_hold_req = 1'b0;
               holds_done++;
            end else begin
               phase++;
               case (mode)
                  RX_FREE:   rsp_if.ready <= 1'b1;
                  RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
                  RX_THIRDS: rsp_if.ready <= (phase % 3 != 0);
                  default:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // checker: every response against the oldest owed one, field by field
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (list_results_due.size() == 0) begin
            report_mismatch($sformatf("response %0d with nothing owed (element %0d count %0d)",
                                      results_seen, rsp_if.element, rsp_if.count));
         end else begin
            want = list_results_due.pop_front();
            if (rsp_if.element !== want.element)
               report_mismatch($sformatf("response %0d element %0d, wanted %0d",
                                         results_seen, rsp_if.element, want.element));
            if (rsp_if.has_element !== want.has_element)
               report_mismatch($sformatf("response %0d has_element %0b, wanted %0b",
                                         results_seen, rsp_if.has_element, want.has_element));
            if (rsp_if.status !== want.status)
               report_mismatch($sformatf("response %0d status %0d, wanted %0d",
                                         results_seen, rsp_if.status, want.status));
            if (rsp_if.count !== want.count)
               report_mismatch($sformatf("response %0d count %0d, wanted %0d",
                                         results_seen, rsp_if.count, want.count));
            if (rsp_if.last !== want.last)
               report_mismatch($sformatf("response %0d last %0b, wanted %0b",
                                         results_seen, rsp_if.last, want.last));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too long with no transaction on either channel means a hang
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no transaction for %0d cycles, %0d response(s) still owed",
                  STALL_LIMIT, list_results_due.size());
         $display("FAIL");
         $finish;
      end
   end

endmodule
